// ----- sv/tcb_pkg.sv -----
// Shared types and constants for the text cell buffer with ring scroll.
`timescale 1ns / 1ps
`default_nettype none
package tcb_pkg;

  localparam int CFG_W = 7;
  localparam int MOD_W = 8;

  localparam logic [CFG_W-1:0] COLS_RESET = 7'd80;
  localparam logic [CFG_W-1:0] ROWS_RESET = 7'd60;

  localparam logic [15:0] BLANK_CODE = 16'h0020;
  localparam logic [15:0] BOLD_BIT   = 16'h0100;

  localparam logic [2:0] FL_BOLD  = 3'b001;
  localparam logic [2:0] FL_LEFT  = 3'b010;
  localparam logic [2:0] FL_RIGHT = 3'b100;

  typedef enum logic [3:0] {
    FN_PUT         = 4'd0,
    FN_PUT_BOLD    = 4'd1,
    FN_WIDE        = 4'd2,
    FN_WIDE_BOLD   = 4'd3,
    FN_CLEAR_ALL   = 4'd4,
    FN_CLEAR_LINE  = 4'd5,
    FN_CLEAR_RANGE = 4'd6,
    FN_UP          = 4'd7,
    FN_DOWN        = 4'd8,
    FN_SET_ATTR    = 4'd9,
    FN_GET_ATTR    = 4'd10,
    FN_READ        = 4'd11
  } func_t;

  typedef enum logic {
    CFG_COLS = 1'b0,
    CFG_ROWS = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [2:0]  flags;
    logic [7:0]  attr;
    logic [15:0] code;
  } cell_t;

endpackage
`default_nettype wire

// ----- sv/tcb_mod.sv -----
// Bit-serial remainder unit used for the ring row mapping.
`timescale 1ns / 1ps
`default_nettype none
module tcb_mod
  import tcb_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [MOD_W-1:0] dividend,
  input  wire logic [CFG_W-1:0] divisor,
  output logic                  done,
  output logic [CFG_W-1:0]      rem
);

  localparam int CNT_W = $clog2(MOD_W);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [MOD_W-1:0] sh_r;
  logic [CFG_W-1:0] rem_r;
  logic [CFG_W-1:0] rem_nxt;
  logic [CFG_W:0]   trial;

  always_comb begin
    trial = {rem_r, sh_r[MOD_W-1]};
    if (trial >= {1'b0, divisor}) begin
      rem_nxt = CFG_W'(trial - {1'b0, divisor});
    end else begin
      rem_nxt = CFG_W'(trial);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !start && (cnt_r == CNT_W'(MOD_W - 1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        sh_r   <= dividend;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        sh_r  <= {sh_r[MOD_W-2:0], 1'b0};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(MOD_W - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule
`default_nettype wire

// ----- sv/text_cell_buffer_ring_scroll_unit.sv -----
// Top level of the text cell buffer with ring-scrolled row origin.
// One command is taken at a time; the result sits in an output register, so
// the next command is accepted while it waits. After reset the block clears
// the row wide marks of every row (MAX_ROWS, at most 127; 64 by default)
// and takes no command meanwhile. Each accepted cell, line or range command
// first maps its logical row through a bit-serial remainder unit, then
// multiplies the physical row by the column count and works on the single-port
// cell memory; a scroll maps its ring origin the same way for each row it
// moves. Clear line sweeps the active columns of its row, clear range its
// width, and clear all (or a scroll of at least active_rows) the whole active
// screen. The cell memory has no reset: a cell reads back only after a command
// has written it, which clear all guarantees.
`timescale 1ns / 1ps
`default_nettype none
module text_cell_buffer_ring_scroll_unit
  import tcb_pkg::*;
#(
  parameter int MAX_COLS = 80,
  parameter int MAX_ROWS = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [3:0]        in_func,
  input  wire logic signed [7:0] in_col,
  input  wire logic signed [7:0] in_row,
  input  wire logic [15:0]       in_code,
  input  wire logic [7:0]        in_attr,
  input  wire logic signed [8:0] in_count,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [15:0]            out_read_code,
  output logic [7:0]             out_read_attr,
  output logic [2:0]             out_read_flags,
  output logic                   out_read_row_wide,
  output logic                   out_rejected,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data
);

  localparam int COL_CAP = (MAX_COLS > 127) ? 127 : MAX_COLS;
  localparam int ROW_CAP = (MAX_ROWS > 127) ? 127 : MAX_ROWS;
  localparam int ROW_IW  = (ROW_CAP > 1) ? $clog2(ROW_CAP) : 1;
  localparam int DEPTH   = MAX_COLS * MAX_ROWS;
  localparam int AW      = $clog2(DEPTH);
  localparam int AW1     = $clog2(DEPTH + 1);
  localparam int PW      = 2 * CFG_W;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_DECODE, S_MOD, S_MUL, S_SETUP, S_CELL, S_WIDE2, S_RDUSE, S_SWEEP,
    S_OUT
  } state_t;

  state_t             state_r;
  func_t              func_r;
  logic signed [7:0]  col_r;
  logic signed [7:0]  row_r;
  logic [15:0]        code_r;
  logic [7:0]         attr_r;
  logic signed [8:0]  count_r;
  logic               all_r;
  logic [CFG_W-1:0]   steps_r;
  logic [ROW_IW-1:0]  line_r;
  logic [ROW_IW-1:0]  offset_r;
  logic [CFG_W-1:0]   mrow_r;
  logic [AW1-1:0]     prod_r;
  logic [AW1-1:0]     addr_r;
  logic [AW1-1:0]     end_r;
  logic [AW1-1:0]     addr_nxt;
  logic               mod_start_r;
  logic [MOD_W-1:0]   mod_dvd_r;
  logic               mod_done;
  logic [CFG_W-1:0]   mod_rem;
  logic [CFG_W-1:0]   cols_cfg_r;
  logic [CFG_W-1:0]   rows_cfg_r;
  logic [CFG_W-1:0]   cols;
  logic [CFG_W-1:0]   rows;
  logic [15:0]        res_code_r;
  logic [7:0]         res_attr_r;
  logic [2:0]         res_flags_r;
  logic               res_wide_r;
  logic               rej_r;
  logic               out_valid_r;
  logic [15:0]        out_code_r;
  logic [7:0]         out_attr_r;
  logic [2:0]         out_flags_r;
  logic               out_wide_r;
  logic               out_rej_r;

  cell_t              mem [DEPTH];
  cell_t              rdata_r;
  logic               mem_we;
  cell_t              mem_wdata;

  logic               marks [ROW_CAP];
  logic               mark_rd_r;
  logic               mark_we;
  logic [ROW_IW-1:0]  mark_addr;
  logic               mark_wdata;

  logic               row_ok;
  logic               cell_ok;
  logic               wide_ok;
  logic               is_bold;
  logic               is_scroll;
  logic signed [9:0]  rng_start;
  logic signed [9:0]  rng_end;
  logic signed [9:0]  rng_end_c;
  logic signed [9:0]  cols_s;
  logic               rng_empty;
  logic [CFG_W-1:0]   mul_a;
  logic [PW-1:0]      mul_p;
  logic [CFG_W-1:0]   dn_line;
  logic [CFG_W-1:0]   up_off;

  always_comb begin
    if (cols_cfg_r < 7'd2) begin
      cols = 7'd2;
    end else if (cols_cfg_r > CFG_W'(COL_CAP)) begin
      cols = CFG_W'(COL_CAP);
    end else begin
      cols = cols_cfg_r;
    end
    if (rows_cfg_r < 7'd1) begin
      rows = 7'd1;
    end else if (rows_cfg_r > CFG_W'(ROW_CAP)) begin
      rows = CFG_W'(ROW_CAP);
    end else begin
      rows = rows_cfg_r;
    end
  end

  always_comb begin
    row_ok    = !row_r[7] && (row_r[6:0] < rows);
    cell_ok   = row_ok && !col_r[7] && (col_r[6:0] < cols);
    wide_ok   = row_ok && !col_r[7] && (({1'b0, col_r[6:0]} + 8'd1) < {1'b0, cols});
    is_bold   = (func_r == FN_PUT_BOLD) || (func_r == FN_WIDE_BOLD);
    is_scroll = (func_r == FN_UP) || (func_r == FN_DOWN);
    cols_s    = $signed({3'b000, cols});
    rng_start = col_r[7] ? 10'sd0 : $signed({3'b000, col_r[6:0]});
    rng_end   = $signed({{2{col_r[7]}}, col_r}) + $signed({count_r[8], count_r});
    rng_end_c = (rng_end > cols_s) ? cols_s : rng_end;
    rng_empty = (rng_end_c <= rng_start);
    mul_a     = all_r ? rows : CFG_W'(line_r);
    mul_p     = PW'(mul_a) * PW'(cols);
    dn_line   = (mod_rem == '0) ? rows - 1'b1 : mod_rem - 1'b1;
    up_off    = ((mod_rem + 1'b1) == rows) ? '0 : mod_rem + 1'b1;
    addr_nxt  = addr_r + 1'b1;
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = '{flags: '0, attr: attr_r, code: BLANK_CODE};
    unique case (state_r)
      S_CELL: begin
        case (func_r) inside
          FN_PUT, FN_PUT_BOLD: begin
            mem_we    = 1'b1;
            mem_wdata = '{flags: is_bold ? FL_BOLD : 3'b000, attr: attr_r,
                          code: 16'(code_r[7:0]) | (is_bold ? BOLD_BIT : 16'h0000)};
          end
          FN_WIDE, FN_WIDE_BOLD: begin
            mem_we    = 1'b1;
            mem_wdata = '{flags: FL_LEFT | (is_bold ? FL_BOLD : 3'b000), attr: attr_r,
                          code: code_r};
          end
          default: mem_we = 1'b0;
        endcase
      end
      S_WIDE2: begin
        mem_we    = 1'b1;
        mem_wdata = '{flags: FL_RIGHT | (is_bold ? FL_BOLD : 3'b000), attr: attr_r,
                      code: 16'h0000};
      end
      S_RDUSE: begin
        if (func_r == FN_SET_ATTR) begin
          mem_we    = 1'b1;
          mem_wdata = '{flags: rdata_r.flags, attr: attr_r, code: rdata_r.code};
        end
      end
      S_SWEEP: mem_we = 1'b1;
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr_r[AW-1:0]] <= mem_wdata;
    end
    rdata_r <= mem[addr_r[AW-1:0]];
  end

  always_comb begin
    mark_we    = 1'b0;
    mark_addr  = line_r;
    mark_wdata = 1'b0;
    unique case (state_r)
      S_INIT: begin
        mark_we   = 1'b1;
        mark_addr = ROW_IW'(mrow_r);
      end
      S_SETUP: mark_we = !all_r && ((func_r == FN_CLEAR_LINE) || is_scroll);
      S_CELL: begin
        mark_we    = (func_r == FN_WIDE) || (func_r == FN_WIDE_BOLD);
        mark_wdata = 1'b1;
      end
      S_SWEEP: begin
        mark_we   = all_r && (mrow_r < rows);
        mark_addr = ROW_IW'(mrow_r);
      end
      default: mark_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mark_we) begin
      marks[mark_addr] <= mark_wdata;
    end
    mark_rd_r <= marks[line_r];
  end

  tcb_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start_r),
    .dividend (mod_dvd_r),
    .divisor  (rows),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      cols_cfg_r  <= COLS_RESET;
      rows_cfg_r  <= ROWS_RESET;
      offset_r    <= '0;
      mrow_r      <= '0;
      all_r       <= 1'b0;
      mod_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (mod_start_r) begin
        mod_start_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_COLS: cols_cfg_r <= cfg_data;
          CFG_ROWS: rows_cfg_r <= cfg_data;
        endcase
      end
      if (out_valid_r && out_ready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_INIT: begin
          mrow_r <= mrow_r + 1'b1;
          if (mrow_r == CFG_W'(ROW_CAP - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            func_r      <= func_t'(in_func);
            col_r       <= in_col;
            row_r       <= in_row;
            code_r      <= in_code;
            attr_r      <= in_attr;
            count_r     <= in_count;
            res_code_r  <= '0;
            res_attr_r  <= '0;
            res_flags_r <= '0;
            res_wide_r  <= 1'b0;
            rej_r       <= 1'b0;
            all_r       <= 1'b0;
            state_r     <= S_DECODE;
          end
        end
        S_DECODE: begin
          unique case (func_r) inside
            FN_PUT, FN_PUT_BOLD, FN_SET_ATTR, FN_GET_ATTR, FN_READ: begin
              if (!cell_ok) begin
                rej_r   <= 1'b1;
                state_r <= S_OUT;
              end else begin
                mod_start_r <= 1'b1;
                mod_dvd_r   <= MOD_W'(row_r[6:0]) + MOD_W'(offset_r);
                state_r     <= S_MOD;
              end
            end
            FN_WIDE, FN_WIDE_BOLD: begin
              if (!wide_ok) begin
                rej_r   <= 1'b1;
                state_r <= S_OUT;
              end else begin
                mod_start_r <= 1'b1;
                mod_dvd_r   <= MOD_W'(row_r[6:0]) + MOD_W'(offset_r);
                state_r     <= S_MOD;
              end
            end
            FN_CLEAR_LINE, FN_CLEAR_RANGE: begin
              if (!row_ok || (func_r == FN_CLEAR_RANGE && rng_empty)) begin
                rej_r   <= 1'b1;
                state_r <= S_OUT;
              end else begin
                mod_start_r <= 1'b1;
                mod_dvd_r   <= MOD_W'(row_r[6:0]) + MOD_W'(offset_r);
                state_r     <= S_MOD;
              end
            end
            FN_CLEAR_ALL: begin
              all_r   <= 1'b1;
              state_r <= S_MUL;
            end
            FN_UP, FN_DOWN: begin
              if (count_r[8] || count_r == '0) begin
                rej_r   <= 1'b1;
                state_r <= S_OUT;
              end else if (count_r[7:0] >= {1'b0, rows}) begin
                all_r   <= 1'b1;
                state_r <= S_MUL;
              end else begin
                steps_r     <= count_r[6:0];
                mod_start_r <= 1'b1;
                mod_dvd_r   <= MOD_W'(offset_r);
                state_r     <= S_MOD;
              end
            end
            default: begin
              rej_r   <= 1'b1;
              state_r <= S_OUT;
            end
          endcase
        end
        S_MOD: begin
          if (mod_done) begin
            if (func_r == FN_DOWN) begin
              line_r   <= ROW_IW'(dn_line);
              offset_r <= ROW_IW'(dn_line);
            end else begin
              line_r <= ROW_IW'(mod_rem);
              if (func_r == FN_UP) begin
                offset_r <= ROW_IW'(up_off);
              end
            end
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          prod_r  <= AW1'(mul_p);
          state_r <= S_SETUP;
        end
        S_SETUP: begin
          if (all_r) begin
            addr_r   <= '0;
            end_r    <= prod_r;
            offset_r <= '0;
            mrow_r   <= '0;
            state_r  <= S_SWEEP;
          end else begin
            case (func_r) inside
              FN_CLEAR_LINE, FN_UP, FN_DOWN: begin
                addr_r  <= prod_r;
                end_r   <= prod_r + AW1'(cols);
                state_r <= S_SWEEP;
              end
              FN_CLEAR_RANGE: begin
                addr_r  <= prod_r + AW1'(rng_start[6:0]);
                end_r   <= prod_r + AW1'(rng_end_c[6:0]);
                state_r <= S_SWEEP;
              end
              default: begin
                addr_r  <= prod_r + AW1'(col_r[6:0]);
                state_r <= S_CELL;
              end
            endcase
          end
        end
        S_CELL: begin
          case (func_r) inside
            FN_PUT, FN_PUT_BOLD: state_r <= S_OUT;
            FN_WIDE, FN_WIDE_BOLD: begin
              addr_r  <= addr_nxt;
              state_r <= S_WIDE2;
            end
            default: state_r <= S_RDUSE;
          endcase
        end
        S_WIDE2: state_r <= S_OUT;
        S_RDUSE: begin
          case (func_r)
            FN_GET_ATTR: res_attr_r <= rdata_r.attr;
            FN_READ: begin
              res_code_r  <= rdata_r.code;
              res_attr_r  <= rdata_r.attr;
              res_flags_r <= rdata_r.flags;
              res_wide_r  <= mark_rd_r;
            end
            default: res_attr_r <= '0;
          endcase
          state_r <= S_OUT;
        end
        S_SWEEP: begin
          addr_r <= addr_nxt;
          if (all_r && mrow_r < rows) begin
            mrow_r <= mrow_r + 1'b1;
          end
          if (addr_nxt == end_r) begin
            if (!all_r && is_scroll && steps_r > 7'd1) begin
              steps_r     <= steps_r - 1'b1;
              mod_start_r <= 1'b1;
              mod_dvd_r   <= MOD_W'(offset_r);
              state_r     <= S_MOD;
            end else begin
              state_r <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_code_r  <= res_code_r;
            out_attr_r  <= res_attr_r;
            out_flags_r <= res_flags_r;
            out_wide_r  <= res_wide_r;
            out_rej_r   <= rej_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready          = (state_r == S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_read_code     = out_code_r;
  assign out_read_attr     = out_attr_r;
  assign out_read_flags    = out_flags_r;
  assign out_read_row_wide = out_wide_r;
  assign out_rejected      = out_rej_r;

endmodule
`default_nettype wire

// ----- sv/tcb_checker.sv -----
// Port-level checks on the result channel of the text cell buffer.
`timescale 1ns / 1ps
`default_nettype none
module tcb_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] out_read_code,
  input wire logic [7:0]  out_read_attr,
  input wire logic [2:0]  out_read_flags,
  input wire logic        out_read_row_wide,
  input wire logic        out_rejected
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_code)
      && $stable(out_read_attr) && $stable(out_read_flags)
      && $stable(out_read_row_wide) && $stable(out_rejected))
    else $error("result beat changed while stalled");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rejected |-> out_read_code == 16'h0000 && out_read_attr == 8'h00
      && out_read_flags == 3'b000 && !out_read_row_wide)
    else $error("rejected beat carries data");

  a_right_half: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_read_flags[2] |-> !out_read_flags[1] && out_read_code == 16'h0000)
    else $error("right half of wide cell malformed");

  a_bold_narrow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_read_flags == 3'b001 |-> out_read_code[8])
    else $error("bold narrow cell lacks bold code bit");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind text_cell_buffer_ring_scroll_unit tcb_checker u_tcb_checker (.*);
`default_nettype wire

// ----- sim/tb.sv -----
// Self-checking testbench for the text cell buffer with ring-scrolled row origin.
`timescale 1ns / 1ps
module tb;
  import tcb_pkg::*;

  localparam int CLK_HALF        = 4;
  localparam int RESET_CYCLES    = 6;
  localparam int TAIL_CYCLES     = 200;
  localparam int MAX_COLS        = 80;
  localparam int MAX_ROWS        = 64;
  localparam int MIN_COLS        = 2;
  localparam int MIN_ROWS        = 1;
  localparam int CELL_COUNT      = MAX_COLS * MAX_ROWS;
  localparam int DIR_COUNT       = 28;
  localparam int PHASE_COUNT     = 8;
  localparam int ITEMS_PER_PHASE = 115;
  localparam int HOLD_AT_A       = 300;
  localparam int HOLD_AT_B       = 700;
  localparam int LONG_HOLD       = 600;
  localparam longint TIMEOUT_NS  = 200_000_000;

  localparam logic [3:0] FN_UNUSED_LO = 4'hC;
  localparam logic [3:0] FUNC_MAX     = 4'hF;

  localparam logic signed [7:0] COORD_MIN = 8'sh80;
  localparam logic signed [7:0] COORD_MAX = 8'sh7F;
  localparam logic signed [8:0] CNT_MIN   = 9'sh100;
  localparam logic signed [8:0] CNT_MAX   = 9'sh0FF;

  typedef struct packed {
    logic [3:0]        func;
    logic signed [7:0] col;
    logic signed [7:0] row;
    logic [15:0]       code;
    logic [7:0]        attr;
    logic signed [8:0] count;
  } cmd_t;

  typedef struct packed {
    logic [15:0] code;
    logic [7:0]  attr;
    logic [2:0]  flags;
    logic        row_wide;
    logic        rejected;
  } result_t;

  typedef struct packed {
    cmd_t    cmd;
    logic    typed;
    result_t res;
  } dir_row_t;

  localparam result_t NO_RES   = '0;
  localparam result_t REJ      = '{16'h0000, 8'h00, 3'b000, 1'b0, 1'b1};
  localparam result_t BLANK_FF = '{BLANK_CODE, 8'hFF, 3'b000, 1'b0, 1'b0};
  localparam result_t LOW_BYTE = '{16'h00FF, 8'h00, 3'b000, 1'b0, 1'b0};

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [3:0]             in_func = '0;
  logic signed [7:0]      in_col = '0;
  logic signed [7:0]      in_row = '0;
  logic [15:0]            in_code = '0;
  logic [7:0]             in_attr = '0;
  logic signed [8:0]      in_count = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [15:0]            out_read_code;
  logic [7:0]             out_read_attr;
  logic [2:0]             out_read_flags;
  logic                   out_read_row_wide;
  logic                   out_rejected;
  logic                   cfg_we = 1'b0;
  logic                   cfg_index = 1'b0;
  logic [CFG_W-1:0]       cfg_data = '0;

  text_cell_buffer_ring_scroll_unit uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_func           (in_func),
    .in_col            (in_col),
    .in_row            (in_row),
    .in_code           (in_code),
    .in_attr           (in_attr),
    .in_count          (in_count),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_read_code     (out_read_code),
    .out_read_attr     (out_read_attr),
    .out_read_flags    (out_read_flags),
    .out_read_row_wide (out_read_row_wide),
    .out_rejected      (out_rejected),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  initial begin
    #TIMEOUT_NS;
    $display("CHECKS FAILED");
    $finish;
  end

  // shadow screen state
  cell_t            screen_cells [CELL_COUNT];
  bit               cell_written [CELL_COUNT];
  bit               row_wide_mark [MAX_ROWS];
  int               ring_origin;
  logic [CFG_W-1:0] cols_setting;
  logic [CFG_W-1:0] rows_setting;

  result_t          expected_results [$];
  int               fail_count = 0;
  int               burst_left = 0;
  result_t          got_result;
  result_t          want_result;
  int               results_seen = 0;
  int               hold_left = 0;
  int               stall_mode = 0;
  int               mode_left = 0;
  logic [CFG_W-1:0] phase_cols [PHASE_COUNT];
  logic [CFG_W-1:0] phase_rows [PHASE_COUNT];

  dir_row_t directed_rows [DIR_COUNT] = '{
    '{'{FN_READ, 8'sd0, COORD_MIN, 16'h0000, 8'h00, 9'sd0}, 1'b1, REJ},
    '{'{FN_GET_ATTR, COORD_MAX, 8'sd0, 16'h0000, 8'h00, 9'sd0}, 1'b1, REJ},
    '{'{FUNC_MAX, 8'sd0, 8'sd0, 16'h0000, 8'h00, 9'sd0}, 1'b1, REJ},
    '{'{FN_CLEAR_ALL, COORD_MIN, COORD_MIN, 16'hFFFF, 8'hFF, CNT_MIN}, 1'b1, NO_RES},
    '{'{FN_READ, 8'sd79, 8'sd59, 16'h0000, 8'h00, 9'sd0}, 1'b1, BLANK_FF},
    '{'{FN_PUT, 8'sd0, 8'sd0, 16'hFFFF, 8'h00, 9'sd0}, 1'b1, NO_RES},
    '{'{FN_READ, 8'sd0, 8'sd0, 16'h0000, 8'h00, 9'sd0}, 1'b1, LOW_BYTE},
    '{'{FN_PUT_BOLD, 8'sd1, 8'sd0, 16'h1234, 8'hA5, 9'sd0}, 1'b0, NO_RES},
    '{'{FN_READ, 8'sd1, 8'sd0, 16'h0000, 8'h00, 9'sd0}, 1'b0, NO_RES},
    '{'{FN_WIDE, 8'sd78, 8'sd59, 16'hBEEF, 8'h5A, 9'sd0}, 1'b0, NO_RES},
    '{'{FN_WIDE, 8'sd79, 8'sd0, 16'h4321, 8'h01, 9'sd0}, 1'b1, REJ},
    '{'{FN_WIDE_BOLD, 8'sd0, 8'sd1, 16'h8001, 8'h3C, 9'sd0}, 1'b0, NO_RES},
    '{'{FN_READ, 8'sd1, 8'sd1, 16'h0000, 8'h00, 9'sd0}, 1'b0, NO_RES},
    '{'{FN_READ, 8'sd78, 8'sd59, 16'h0000, 8'h00, 9'sd0}, 1'b0, NO_RES},
    '{'{FN_CLEAR_RANGE, -8'sd5, 8'sd59, 16'h0000, 8'h11, 9'sd8}, 1'b0, NO_RES},
    '{'{FN_CLEAR_RANGE, 8'sd75, 8'sd0, 16'h0000, 8'h12, CNT_MAX}, 1'b0, NO_RES},
    '{'{FN_CLEAR_RANGE, -8'sd10, 8'sd0, 16'h0000, 8'h00, 9'sd10}, 1'b1, REJ},
    '{'{FN_CLEAR_RANGE, 8'sd0, 8'sd0, 16'h0000, 8'h00, CNT_MIN}, 1'b1, REJ},
    '{'{FN_UP, 8'sd0, 8'sd0, 16'h0000, 8'h22, 9'sd3}, 1'b0, NO_RES},
    '{'{FN_DOWN, 8'sd0, 8'sd0, 16'h0000, 8'h33, 9'sd1}, 1'b0, NO_RES},
    '{'{FN_UP, 8'sd0, 8'sd0, 16'h0000, 8'h00, 9'sd0}, 1'b1, REJ},
    '{'{FN_DOWN, 8'sd0, 8'sd0, 16'h0000, 8'h00, -9'sd1}, 1'b1, REJ},
    '{'{FN_SET_ATTR, 8'sd79, 8'sd59, 16'h0000, 8'h77, 9'sd0}, 1'b0, NO_RES},
    '{'{FN_GET_ATTR, 8'sd79, 8'sd59, 16'h0000, 8'h00, 9'sd0}, 1'b0, NO_RES},
    '{'{FN_CLEAR_LINE, 8'sd0, 8'sd59, 16'h0000, 8'h44, 9'sd0}, 1'b0, NO_RES},
    '{'{FN_CLEAR_LINE, 8'sd0, 8'sd60, 16'h0000, 8'h44, 9'sd0}, 1'b1, REJ},
    '{'{FN_DOWN, 8'sd0, 8'sd0, 16'h0000, 8'h66, 9'sd60}, 1'b0, NO_RES},
    '{'{FN_READ, 8'sd0, 8'sd1, 16'h0000, 8'h00, 9'sd0}, 1'b0, NO_RES}
  };

  function automatic int eff_cols();
    int c;
    c = int'(cols_setting);
    if (c < MIN_COLS) c = MIN_COLS;
    if (c > MAX_COLS) c = MAX_COLS;
    return c;
  endfunction

  function automatic int eff_rows();
    int r;
    r = int'(rows_setting);
    if (r < MIN_ROWS) r = MIN_ROWS;
    if (r > MAX_ROWS) r = MAX_ROWS;
    return r;
  endfunction

  function automatic int map_row(input int logical);
    return (logical + ring_origin) % eff_rows();
  endfunction

  function automatic void blank_cell(input int idx, input logic [7:0] fill);
    screen_cells[idx] = '{flags: 3'b000, attr: fill, code: BLANK_CODE};
    cell_written[idx] = 1'b1;
  endfunction

  function automatic void blank_line(input int phys, input logic [7:0] fill);
    int cols;
    cols = eff_cols();
    for (int i = 0; i < cols; i++) blank_cell(phys * cols + i, fill);
    row_wide_mark[phys] = 1'b0;
  endfunction

  function automatic void blank_screen(input logic [7:0] fill);
    int rows;
    rows = eff_rows();
    for (int r = 0; r < rows; r++) blank_line(r, fill);
    ring_origin = 0;
  endfunction

  function automatic void reset_screen();
    for (int i = 0; i < CELL_COUNT; i++) cell_written[i] = 1'b0;
    for (int r = 0; r < MAX_ROWS; r++) row_wide_mark[r] = 1'b0;
    ring_origin = 0;
    cols_setting = COLS_RESET;
    rows_setting = ROWS_RESET;
  endfunction

  function automatic result_t apply_command(input cmd_t c);
    result_t   r;
    cell_t     nc;
    logic [2:0] bold_fl;
    int        cols, rows, col_i, row_i, cnt, phys, idx, start, width;
    bit        row_ok, cell_ok;
    r = '0;
    cols = eff_cols();
    rows = eff_rows();
    col_i = $signed(c.col);
    row_i = $signed(c.row);
    cnt = $signed(c.count);
    row_ok = row_i >= 0 && row_i < rows;
    cell_ok = row_ok && col_i >= 0 && col_i < cols;
    phys = row_ok ? map_row(row_i) : 0;
    idx = phys * cols + col_i;
    case (c.func)
      FN_PUT, FN_PUT_BOLD: begin
        if (!cell_ok) begin
          r.rejected = 1'b1;
        end else begin
          nc = '{flags: 3'b000, attr: c.attr, code: {8'h00, c.code[7:0]}};
          if (c.func == FN_PUT_BOLD) begin
            nc.flags = FL_BOLD;
            nc.code = nc.code | BOLD_BIT;
          end
          screen_cells[idx] = nc;
          cell_written[idx] = 1'b1;
        end
      end
      FN_WIDE, FN_WIDE_BOLD: begin
        bold_fl = (c.func == FN_WIDE_BOLD) ? FL_BOLD : 3'b000;
        if (!row_ok || col_i < 0 || col_i + 1 >= cols) begin
          r.rejected = 1'b1;
        end else begin
          screen_cells[idx] = '{flags: FL_LEFT | bold_fl, attr: c.attr, code: c.code};
          screen_cells[idx + 1] = '{flags: FL_RIGHT | bold_fl, attr: c.attr, code: 16'h0000};
          cell_written[idx] = 1'b1;
          cell_written[idx + 1] = 1'b1;
          row_wide_mark[phys] = 1'b1;
        end
      end
      FN_CLEAR_ALL: blank_screen(c.attr);
      FN_CLEAR_LINE: begin
        if (!row_ok) r.rejected = 1'b1;
        else blank_line(phys, c.attr);
      end
      FN_CLEAR_RANGE: begin
        start = col_i;
        width = cnt;
        if (start < 0) begin
          width = width + start;
          start = 0;
        end
        if (start + width > cols) width = cols - start;
        if (!row_ok || width <= 0) begin
          r.rejected = 1'b1;
        end else begin
          for (int i = 0; i < width; i++) blank_cell(phys * cols + start + i, c.attr);
        end
      end
      FN_UP, FN_DOWN: begin
        if (cnt <= 0) begin
          r.rejected = 1'b1;
        end else if (cnt >= rows) begin
          blank_screen(c.attr);
        end else begin
          for (int i = 0; i < cnt; i++) begin
            if (c.func == FN_UP) begin
              blank_line(map_row(0), c.attr);
              ring_origin = (ring_origin % rows + 1) % rows;
            end else begin
              ring_origin = (ring_origin % rows + rows - 1) % rows;
              blank_line(map_row(0), c.attr);
            end
          end
        end
      end
      FN_SET_ATTR: begin
        if (!cell_ok) r.rejected = 1'b1;
        else screen_cells[idx].attr = c.attr;
      end
      FN_GET_ATTR: begin
        if (!cell_ok) r.rejected = 1'b1;
        else r.attr = screen_cells[idx].attr;
      end
      FN_READ: begin
        if (!cell_ok) begin
          r.rejected = 1'b1;
        end else begin
          r.code = screen_cells[idx].code;
          r.attr = screen_cells[idx].attr;
          r.flags = screen_cells[idx].flags;
          r.row_wide = row_wide_mark[phys];
        end
      end
      default: r.rejected = 1'b1;
    endcase
    return r;
  endfunction

  function automatic cmd_t random_command();
    cmd_t c;
    int   cols, rows, pick, sel, col_i, row_i;
    bit   wild;
    cols = eff_cols();
    rows = eff_rows();
    pick = $urandom_range(0, 99);
    wild = ($urandom_range(0, 9) == 0);
    c.func = FN_READ;
    c.col = 8'($urandom);
    c.row = 8'($urandom);
    c.code = 16'($urandom);
    c.attr = 8'($urandom);
    c.count = 9'($urandom);
    if (!wild) begin
      c.col = 8'($urandom_range(0, cols - 1));
      c.row = 8'($urandom_range(0, rows - 1));
    end
    if (pick < 22) begin
      c.func = $urandom_range(0, 1) ? FN_PUT_BOLD : FN_PUT;
    end else if (pick < 32) begin
      c.func = $urandom_range(0, 1) ? FN_WIDE_BOLD : FN_WIDE;
      if (!wild) c.col = 8'($urandom_range(0, cols - 2));
    end else if (pick < 56) begin
      c.func = FN_READ;
    end else if (pick < 63) begin
      c.func = FN_GET_ATTR;
    end else if (pick < 70) begin
      c.func = FN_SET_ATTR;
    end else if (pick < 72) begin
      c.func = FN_CLEAR_ALL;
    end else if (pick < 76) begin
      c.func = FN_CLEAR_LINE;
    end else if (pick < 83) begin
      c.func = FN_CLEAR_RANGE;
      if (!wild) begin
        c.col = 8'(int'($urandom_range(0, cols + 8)) - 8);
        c.count = 9'(int'($urandom_range(0, cols + 8)) - 4);
      end
    end else if (pick < 92) begin
      c.func = $urandom_range(0, 1) ? FN_DOWN : FN_UP;
      sel = $urandom_range(0, 9);
      if (sel < 6) c.count = 9'($urandom_range(1, 3));
      else if (sel == 6) c.count = 9'(rows - 1);
      else if (sel == 7) c.count = 9'(rows + int'($urandom_range(0, 8)));
      else if (sel == 8) c.count = 9'(0 - int'($urandom_range(0, 3)));
    end else if (pick < 96) begin
      c.func = 4'($urandom_range(FN_UNUSED_LO, FUNC_MAX));
    end else begin
      c.func = 4'($urandom);
    end
    // never touch a cell that holds nothing defined yet
    col_i = $signed(c.col);
    row_i = $signed(c.row);
    if ((c.func == FN_SET_ATTR || c.func == FN_GET_ATTR || c.func == FN_READ) &&
        row_i >= 0 && row_i < rows && col_i >= 0 && col_i < cols &&
        !cell_written[map_row(row_i) * cols + col_i])
      c.func = FN_PUT;
    return c;
  endfunction

  task automatic send_command(input cmd_t c, input logic typed, input result_t typed_res);
    result_t predicted;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_func  <= c.func;
    in_col   <= c.col;
    in_row   <= c.row;
    in_code  <= c.code;
    in_attr  <= c.attr;
    in_count <= c.count;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = apply_command(c);
    expected_results.push_back(typed ? typed_res : predicted);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_geometry(input logic [CFG_W-1:0] cols, input logic [CFG_W-1:0] rows);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_COLS;
    cfg_data  <= cols;
    @(posedge clk);
    cfg_index <= CFG_ROWS;
    cfg_data  <= rows;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cols_setting = cols;
    rows_setting = rows;
  endtask

  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      got_result.code     = out_read_code;
      got_result.attr     = out_read_attr;
      got_result.flags    = out_read_flags;
      got_result.row_wide = out_read_row_wide;
      got_result.rejected = out_rejected;
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("result beat with nothing expected");
        fail_count++;
      end else begin
        want_result = expected_results.pop_front();
        if (got_result.code !== want_result.code) begin
          $error("read_code: expected %h, got %h", want_result.code, got_result.code);
          fail_count++;
        end
        if (got_result.attr !== want_result.attr) begin
          $error("read_attr: expected %h, got %h", want_result.attr, got_result.attr);
          fail_count++;
        end
        if (got_result.flags !== want_result.flags) begin
          $error("read_flags: expected %h, got %h", want_result.flags, got_result.flags);
          fail_count++;
        end
        if (got_result.row_wide !== want_result.row_wide) begin
          $error("read_row_wide: expected %h, got %h",
                 want_result.row_wide, got_result.row_wide);
          fail_count++;
        end
        if (got_result.rejected !== want_result.rejected) begin
          $error("rejected: expected %h, got %h", want_result.rejected, got_result.rejected);
          fail_count++;
        end
      end
      if (results_seen == HOLD_AT_A || results_seen == HOLD_AT_B) hold_left = LONG_HOLD;
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 128);
      end
      mode_left--;
      case (stall_mode)
        0, 1: out_ready <= 1'b1;
        2: out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  initial begin
    reset_screen();
    phase_cols = '{7'd80, 7'd2, 7'd127, 7'd0, 7'($urandom_range(2, 80)), 7'd80,
                   7'($urandom_range(2, 80)), 7'd1};
    phase_rows = '{7'd60, 7'd1, 7'd127, 7'd0, 7'($urandom_range(1, 64)), 7'd64,
                   7'($urandom_range(1, 64)), 7'd65};
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < DIR_COUNT; i++)
      send_command(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].res);
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      drain_results();
      write_geometry(phase_cols[ph], phase_rows[ph]);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) send_command(random_command(), 1'b0, NO_RES);
    end
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/tcb_pkg.sv
sv/tcb_mod.sv
sv/text_cell_buffer_ring_scroll_unit.sv
sv/tcb_checker.sv
sim/tb.sv
